// ----- rtl/frame_rate_window_meter_macros.svh -----
// Assertion macros shared by the frame rate window meter RTL.
// Depends on nothing; every user must have clock aclk and active-low reset aresetn.
`ifndef FRAME_RATE_WINDOW_METER_MACROS_SVH
`define FRAME_RATE_WINDOW_METER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRWM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRWM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// The condition must never be seen.
`define FRWM_ASSERT_NEVER(label, bad, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(bad)) \
        else $error(msg);

`endif

// ----- rtl/frwm_pkg.sv -----
// Package of the frame rate window meter: command type and fixed constants.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package frwm_pkg;

    // Widths that cover the largest supported ring of 64 slots.
    localparam int SLOT_MAX_W = 6;
    localparam int CNT_MAX_W  = 7;

    localparam logic [15:0] COUNT_MAX           = 16'hFFFF;
    localparam logic [15:0] DEFAULT_INTERVAL_MS = 16'd1000;

    // One classified frame, passed from the front end to the back end.
    typedef struct packed {
        logic                  adv;   // frame closes the current interval
        logic [SLOT_MAX_W-1:0] slot;  // slot that was current before this frame
        logic [CNT_MAX_W-1:0]  n;     // number of slots to average when adv is set
    } cmd_t;

endpackage

// ----- rtl/frwm_front.sv -----
// Front end of the frame rate window meter: accepts frames, tracks intervals.
// Depends on frwm_pkg; feeds frwm_queue.
`timescale 1ns / 1ps

module frwm_front #(
    parameter int WINDOW_SLOTS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    output logic                push,
    output frwm_pkg::cmd_t      cmd,
    input  logic                q_full
);
    import frwm_pkg::*;

    localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

    logic [15:0]       interval_reg, interval_next;
    logic [31:0]       start_reg, start_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              full_reg, full_next;

    logic [31:0]       start_eff;
    logic [31:0]       elapsed;
    logic              adv;
    logic [SLOT_W-1:0] slot_inc;
    logic              full_inc;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign push      = s_tvalid && s_tready;

    always_comb begin
        // A start time of zero means the meter has not started yet.
        start_eff = (start_reg == 32'd0) ? s_tdata : start_reg;
        elapsed   = s_tdata - start_eff;
        adv       = (elapsed >= {16'd0, interval_reg});
        slot_inc  = (slot_reg == SLOT_W'(WINDOW_SLOTS - 1)) ? '0
                                                            : SLOT_W'(slot_reg + 1'b1);
        full_inc  = full_reg | (slot_inc == '0);

        interval_next = interval_reg;
        start_next    = start_reg;
        slot_next     = slot_reg;
        full_next     = full_reg;

        if (cfg_valid && cfg_ready) begin
            interval_next = cfg_data;
        end
        if (push) begin
            if (adv) begin
                slot_next  = slot_inc;
                start_next = s_tdata;
                full_next  = full_inc;
            end else begin
                start_next = start_eff;
            end
        end

        cmd.adv  = adv;
        cmd.slot = SLOT_MAX_W'(slot_reg);
        cmd.n    = full_inc ? CNT_MAX_W'(WINDOW_SLOTS) : CNT_MAX_W'(slot_inc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= DEFAULT_INTERVAL_MS;
            start_reg    <= 32'd0;
            slot_reg     <= '0;
            full_reg     <= 1'b0;
        end else begin
            interval_reg <= interval_next;
            start_reg    <= start_next;
            slot_reg     <= slot_next;
            full_reg     <= full_next;
        end
    end

endmodule

// ----- rtl/frwm_queue.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on frwm_pkg for the command type.
`timescale 1ns / 1ps

module frwm_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  frwm_pkg::cmd_t din,
    output logic           full,
    input  logic           pop,
    output frwm_pkg::cmd_t dout,
    output logic           empty
);
    import frwm_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/frwm_back.sv -----
// Back end of the frame rate window meter: slot counters, averaging and output.
// Depends on frwm_pkg and frame_rate_window_meter_macros.svh; fed by frwm_queue.
`timescale 1ns / 1ps

`include "frame_rate_window_meter_macros.svh"

module frwm_back #(
    parameter int WINDOW_SLOTS = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  frwm_pkg::cmd_t q_dout,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata,
    output logic           m_tuser
);
    import frwm_pkg::*;

    localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);
    localparam int SUM_W  = 16 + CNT_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [15:0]       cur_cnt_reg, cur_cnt_next;
    logic [15:0]       avg_reg, avg_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              pend_reg, pend_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       out_data_reg, out_data_next;
    logic              out_upd_reg, out_upd_next;

    // Closed slot counts; the open slot lives in cur_cnt_reg.
    logic [15:0]       mem [WINDOW_SLOTS];
    logic [15:0]       rd_data_reg;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;

    logic [CNT_W:0]    rem_sh;
    logic              ge;

    assign pop      = (state_reg == ST_IDLE) && !q_empty && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_upd_reg;

    always_comb begin
        state_next     = state_reg;
        cur_cnt_next   = cur_cnt_reg;
        avg_next       = avg_reg;
        n_next         = n_reg;
        iss_next       = iss_reg;
        pend_next      = 1'b0;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_upd_next   = out_upd_reg;
        wr_en          = 1'b0;
        wr_addr        = q_dout.slot[SLOT_W-1:0];
        rd_en          = 1'b0;
        rd_addr        = iss_reg[SLOT_W-1:0];
        rem_sh         = {rem_reg, sum_reg[SUM_W-1]};
        ge             = (rem_sh >= {1'b0, n_reg});

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    if (q_dout.adv) begin
                        // Close the open slot, then start the new one with this frame.
                        wr_en        = 1'b1;
                        cur_cnt_next = 16'd1;
                        n_next       = q_dout.n[CNT_W-1:0];
                        iss_next     = '0;
                        sum_next     = '0;
                        state_next   = ST_SUM;
                    end else begin
                        if (cur_cnt_reg != COUNT_MAX) begin
                            cur_cnt_next = cur_cnt_reg + 16'd1;
                        end
                        out_valid_next = 1'b1;
                        out_data_next  = avg_reg;
                        out_upd_next   = 1'b0;
                    end
                end
            end
            ST_SUM: begin
                // One read issued per cycle; its data is added in the cycle after.
                if (iss_reg < n_reg) begin
                    rd_en     = 1'b1;
                    iss_next  = iss_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    sum_next = sum_reg + SUM_W'(rd_data_reg);
                end
                if (!(iss_reg < n_reg) && !pend_reg) begin
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                rem_next     = ge ? CNT_W'(rem_sh - {1'b0, n_reg}) : rem_sh[CNT_W-1:0];
                sum_next     = {sum_reg[SUM_W-2:0], ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCNT_W'(SUM_W - 1)) begin
                    avg_next       = (n_reg == '0) ? 16'd0 : sum_next[15:0];
                    out_valid_next = 1'b1;
                    out_data_next  = avg_next;
                    out_upd_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= cur_cnt_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        iss_reg      <= iss_next;
        sum_reg      <= sum_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        out_data_reg <= out_data_next;
        out_upd_reg  <= out_upd_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_cnt_reg   <= 16'd0;
            avg_reg       <= 16'd0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_cnt_reg   <= cur_cnt_next;
            avg_reg       <= avg_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FRWM_ASSERT_IMP(a_adv_has_slots, pop && q_dout.adv, q_dout.n[CNT_W-1:0] != '0, "advance with no slot to average")
    `FRWM_ASSERT_NEVER(a_busy_no_result, (state_reg != ST_IDLE) && out_valid_reg, "result pending while averaging")
    `FRWM_ASSERT_IMP(a_rem_below_div, state_reg == ST_DIV, rem_reg < n_reg, "division remainder out of range")
    `FRWM_ASSERT_NXT(a_plain_frame_result, pop && !q_dout.adv, out_valid_reg && !out_upd_reg, "plain frame gave no result")

endmodule

// ----- rtl/frame_rate_window_meter.sv -----
// Top level of the frame rate window meter: front end, command queue, back end.
// Depends on frwm_pkg, frwm_front, frwm_queue and frwm_back.
`timescale 1ns / 1ps

//  Channel   Direction  Payload (lowest bit first)              Handshake
//  s_*       in         tdata[31:0] timestamp_ms                tvalid/tready
//  m_*       out        tdata[15:0] rate_value, tuser rate_updated  tvalid/tready
//  cfg_*     in         cfg_data[15:0] interval_ms              cfg_valid/cfg_ready
//
//  The back end takes one frame at a time and no further frame while a result waits on m_*.
//  A frame inside the current interval gives the held rate as a registered result. A frame
//  that closes an interval stores the open slot count and sums the n averaged slots, one
//  memory read per slot, then divides the sum by n, one divider bit per cycle.
//  Reset is synchronous on aresetn low; interval_ms returns to 1000, the open slot count and the held rate to 0.
//  The two-entry queue lets the input keep taking frames while the output is stalled, until it is full.

module frame_rate_window_meter #(
    parameter int WINDOW_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] timestamp_ms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] rate_value
    output logic        m_tuser,   // [0] rate_updated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import frwm_pkg::*;

    // Commands flow front -> queue -> back; each side stalls on its own.
    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // The front end owns the interval timing: slot index, interval start and the
    // wrap flag. It classifies each frame transaction as closing an interval or
    // not, and works out how many slots the new average covers.
    frwm_front #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .cmd       (push_cmd),
        .q_full    (q_full)
    );

    frwm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_cmd),
        .full    (q_full),
        .pop     (pop),
        .dout    (pop_cmd),
        .empty   (q_empty)
    );

    // The back end owns the frame counts. The open slot is a register; closed
    // slots sit in a small memory that is summed one entry per cycle and then
    // divided serially. It produces one result transaction per frame.
    frwm_back #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_dout   (pop_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- sim/tb_frame_rate_window_meter.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for frame_rate_window_meter: streams frame timestamps in,
// predicts every averaged rate from its own slot ring and compares each result.
// Depends on frwm_pkg and the frame_rate_window_meter RTL.

module tb_frame_rate_window_meter;
    import frwm_pkg::*;

    localparam int     RING_SLOTS    = 8;
    localparam int     CLK_PERIOD    = 4;
    localparam int     RESET_CYCLES  = 11;
    // Quiet cycles waited after the last result; they leave the block idle before the next phase.
    localparam int     SETTLE_CYCLES = 64;
    // The run is about 750 frames. Even at the worst legal pace (every frame closing an
    // interval, every stall taken), 2 ms of simulated time leaves a wide margin.
    localparam longint RUN_LIMIT_NS  = 64'd2_000_000;
    localparam int     BURST_FRAMES  = 56;

    // One result as the block reports it.
    typedef struct packed {
        logic [15:0] rate;
        logic        updated;
    } rate_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;    // [31:0] timestamp_ms
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // [15:0] rate_value
    logic        m_tuser;           // [0] rate_updated
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;    // [15:0] interval_ms

    // Timestamps waiting to be driven, and the results the predictor expects.
    logic [31:0]  frame_queue [$];
    rate_result_t rate_expect [$];

    // Set by the posedge process when the input channel completed a transaction, so the
    // driver at the following falling edge knows whether to present the next frame.
    logic s_took = 1'b0;

    // While steady is set neither side inserts idle cycles.
    logic steady = 1'b0;

    int errors         = 0;
    int frames_sent    = 0;
    int interval_close = 0;
    int cfg_writes     = 0;

    // Predictor state: a private copy of the ring of per-interval frame counts.
    logic [15:0] ring_count [RING_SLOTS];
    int          ring_pos;
    logic [31:0] window_start;
    logic        ring_wrapped;
    logic [15:0] held_rate;
    logic [15:0] interval_len;

    frame_rate_window_meter #(
        .WINDOW_SLOTS(RING_SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Each side goes idle at random, with a chance of about six percent, except in the steady stretch.
    function automatic logic take_break();
        return !steady && ($urandom_range(99) < 6);
    endfunction

    task automatic clear_meter();
        int i;
        for (i = 0; i < RING_SLOTS; i++) begin
            ring_count[i] = '0;
        end
        ring_pos     = 0;
        window_start = '0;
        ring_wrapped = 1'b0;
        held_rate    = '0;
        interval_len = DEFAULT_INTERVAL_MS;
    endtask

    // Applies one frame to the predictor and queues the result it must produce.
    task automatic advance_meter(input logic [31:0] stamp);
        logic [31:0]  elapsed;
        logic [31:0]  total;
        int           used;
        int           i;
        rate_result_t res;
        res.updated = 1'b0;
        // A zero start time means the meter has not started, so the frame starts it.
        if (window_start == 32'd0) begin
            window_start = stamp;
        end
        // Elapsed time wraps with the free-running clock.
        elapsed = stamp - window_start;
        if (elapsed >= {16'd0, interval_len}) begin
            ring_pos     = (ring_pos + 1) % RING_SLOTS;
            window_start = stamp;
            if (ring_pos == 0) begin
                ring_wrapped = 1'b1;
            end
            // Average the completed slots, or the whole ring once it has wrapped.
            used  = ring_wrapped ? RING_SLOTS : ring_pos;
            total = '0;
            for (i = 0; i < used; i++) begin
                total += {16'd0, ring_count[i]};
            end
            held_rate = (used != 0) ? 16'(total / 32'(used)) : 16'd0;
            ring_count[ring_pos] = '0;
            res.updated = 1'b1;
            interval_close++;
        end
        // Counts stick at their maximum.
        if (ring_count[ring_pos] != COUNT_MAX) begin
            ring_count[ring_pos]++;
        end
        res.rate = held_rate;
        rate_expect.push_back(res);
    endtask

    task automatic check_result();
        rate_result_t want;
        if (rate_expect.size() == 0) begin
            $error("result without a pending frame: rate_value %0d rate_updated %0d",
                   m_tdata, m_tuser);
            errors++;
        end else begin
            want = rate_expect.pop_front();
            if (m_tdata !== want.rate) begin
                $error("rate_value: expected %0d, got %0d", want.rate, m_tdata);
                errors++;
            end
            if (m_tuser !== want.updated) begin
                $error("rate_updated: expected %0d, got %0d", want.updated, m_tuser);
                errors++;
            end
        end
    endtask

    // Monitor: samples every channel at the rising edge, feeds the predictor with each
    // accepted frame and configuration write, and checks each accepted result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_meter();
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                interval_len = cfg_data;
                cfg_writes++;
            end
            if (s_tvalid && s_tready) begin
                advance_meter(s_tdata);
                frames_sent++;
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
        end
    end

    // Driver: at the falling edge, holds a frame that was not taken yet, otherwise
    // presents the next pending frame unless this cycle is an idle one.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (frame_queue.size() != 0 && !take_break()) begin
                s_tdata  <= frame_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // The result side stalls at random as well.
    always @(negedge aclk) begin
        m_tready <= aresetn && !take_break();
    end

    // Returns once every frame was taken and every result has come back, plus a pause.
    // The check runs at the rising edge, where the driven inputs are stable.
    task automatic wait_idle();
        do begin
            @(posedge aclk);
        end while (frame_queue.size() != 0 || s_tvalid || rate_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_interval(input logic [15:0] value);
        @(negedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Queues a run of frames whose timestamps mostly advance in steps shaped by the
    // interval (inside it, right on it, well past it), with a few random jumps.
    task automatic queue_random(input int count, input logic [15:0] span);
        logic [31:0] stamp;
        int          k;
        int          roll;
        // Some runs start just below the wrap point of the millisecond clock.
        if ($urandom_range(2) == 0) begin
            stamp = 32'hFFFF_FFFF - $urandom_range(4 * int'(span) + 10);
        end else begin
            stamp = $urandom;
        end
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                stamp = $urandom;
            end else if (roll < 60) begin
                stamp += (span > 1) ? $urandom_range(int'(span) - 1) : $urandom_range(1);
            end else if (roll < 72) begin
                stamp += (span > 0) ? span - 1 : 0;
            end else if (roll < 86) begin
                stamp += span;
            end else begin
                stamp += span + $urandom_range(3 * int'(span) + 2);
            end
            frame_queue.push_back(stamp);
        end
    endtask

    initial begin
        logic [31:0] stamp;
        logic [15:0] setting [7];
        int          k;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset interval of 1000 ms. Zero timestamps leave the
        // meter unstarted but are still counted; then a burst of frames at one time
        // piles into slot 0, and the frame that closes it reports that count.
        frame_queue.push_back(32'd0);
        frame_queue.push_back(32'd0);
        frame_queue.push_back(32'd100);
        for (k = 0; k < BURST_FRAMES; k++) begin
            frame_queue.push_back(32'd100);
        end
        frame_queue.push_back(32'd1099);        // one short of the interval
        frame_queue.push_back(32'd1100);        // exactly one interval
        frame_queue.push_back(32'd2099);
        frame_queue.push_back(32'hFFFF_FFF0);   // far jump closes an interval
        frame_queue.push_back(32'h0000_0005);   // clock wrapped, still inside
        frame_queue.push_back(32'h0000_03D8);   // exactly one interval across the wrap
        // Close enough intervals to wrap the ring and average all slots.
        stamp = 32'h0000_03D8;
        for (k = 0; k < 6; k++) begin
            stamp += 32'd1000 + k;
            frame_queue.push_back(stamp);
            frame_queue.push_back(stamp + 32'd7);
        end
        wait_idle();

        // Random part over several interval settings, the extremes among them. A zero
        // interval lies outside the legal range but makes every frame close an interval.
        setting[0] = 16'd1;
        setting[1] = 16'hFFFF;
        setting[2] = 16'd0;
        setting[3] = 16'(1 + $urandom_range(499));
        setting[4] = 16'd1000;
        setting[5] = 16'(1 + $urandom_range(65534));
        setting[6] = 16'd7;
        for (k = 0; k < 7; k++) begin
            write_interval(setting[k]);
            // One whole phase runs without idle cycles on either side.
            steady = (k == 3);
            queue_random(96, setting[k]);
            wait_idle();
        end
        steady = 1'b0;

        if (rate_expect.size() != 0) begin
            $error("%0d expected results never arrived", rate_expect.size());
            errors++;
        end
        $display("Covered %0d frames, a %0d-frame burst into one slot among them,",
                 frames_sent, BURST_FRAMES);
        $display("with %0d interval closes over %0d interval settings.",
                 interval_close, cfg_writes);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
